// ----- hw/rtl/irsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Index record stream parser package
// Shared types and constants: parser phases, result kinds, error codes and
// the result record handed from the step logic to the output register.
// ----------------------------------------------------------------------------
package irsp_pkg;

  localparam int DEF_POSITION_BYTES = 4;

  localparam logic [32:0] TERM_COUNT_MAX = 33'h1_FFFF_FFFF;
  localparam logic [47:0] OCC_MAX        = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    PH_SLOT    = 3'd0,
    PH_CHARSET = 3'd1,
    PH_LEN     = 3'd2,
    PH_TERM    = 3'd3,
    PH_POS     = 3'd4,
    PH_WAIT    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TERM   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_FILE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_BAD_HEADER = 2'd0,
    ERR_TRUNCATED  = 2'd1,
    ERR_BAD_LENGTH = 2'd2,
    ERR_POS_FALLS  = 2'd3
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  term_byte;
    logic [32:0] term_count;
    logic [7:0]  term_length;
    logic        is_prefix;
    err_t        error_code;
    logic [31:0] records_total;
    logic [47:0] occurrences_total;
    logic [31:0] prefix_records_total;
    logic [15:0] files_total;
  } res_t;

endpackage

// ----- hw/rtl/index_record_stream_parser.sv -----
// ----------------------------------------------------------------------------
// Index record stream parser
// The input channel carries one index file byte per beat in in_tdata, with
// in_tlast set on the beat that ends a file (its data is ignored). The
// result channel gives at most one result per input beat: a term byte, a
// finished record with its occurrence count, a finished file, or an error,
// always with the running totals. The result kind travels in out_tuser.
// An input beat is registered on acceptance, and its result is loaded into
// the output register once that register is free or being emptied. The
// parser handles one beat per cycle while the receiver keeps up; the step
// logic updates all of its state as each beat is taken.
// When the receiver stalls, the output register holds its beat and the
// input register still takes one more beat; after that in_tready stays low
// until the receiver takes the held beat. Reset clears both registers, the
// parser returns to waiting for a file header and all totals go to zero.
// ----------------------------------------------------------------------------
module index_record_stream_parser #(
  parameter int POSITION_BYTES = irsp_pkg::DEF_POSITION_BYTES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // end_of_file
  output logic         out_tvalid,
  input  logic         out_tready,
  // term_byte, term_count, term_length, is_prefix, error_code, records_total,
  // occurrences_total, prefix_records_total, files_total, zero padding
  output logic [183:0] out_tdata,
  output logic [1:0]   out_tuser   // kind
);

  logic           in_valid_r, in_valid_nxt;
  logic [7:0]     in_byte_r;
  logic           in_eof_r;
  logic           advance;
  logic           item_en;
  logic           res_valid;
  irsp_pkg::res_t res;
  irsp_pkg::res_t out_res;

  assign item_en   = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (item_en) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eof_r  <= in_tlast;
    end
  end

  irsp_step #(
    .POSITION_BYTES(POSITION_BYTES)
  ) u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_en    (item_en),
    .data_byte  (in_byte_r),
    .end_of_file(in_eof_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  irsp_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (item_en && res_valid),
    .res      (res),
    .can_load (advance),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  assign out_tuser = out_res.kind;
  assign out_tdata = {4'd0,
                      out_res.files_total,
                      out_res.prefix_records_total,
                      out_res.occurrences_total,
                      out_res.records_total,
                      out_res.error_code,
                      out_res.is_prefix,
                      out_res.term_length,
                      out_res.term_count,
                      out_res.term_byte};

endmodule

// ----- hw/rtl/irsp_step.sv -----
// ----------------------------------------------------------------------------
// Index record stream parser step logic
// Holds the parser state and the running totals, and turns one registered
// file beat into at most one result, combinationally.
// ----------------------------------------------------------------------------
module irsp_step #(
  parameter int POSITION_BYTES = irsp_pkg::DEF_POSITION_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_en,
  input  logic [7:0]        data_byte,
  input  logic              end_of_file,
  output logic              res_valid,
  output irsp_pkg::res_t    res
);

  localparam int POS_W = 8 * POSITION_BYTES;
  localparam int CNT_W = (POS_W < 64) ? POS_W + 1 : 64;
  localparam int OS_W  = ((CNT_W > 48) ? CNT_W : 48) + 1;

  irsp_pkg::phase_t   phase_r, phase_nxt;
  logic [7:0]         byte_index_r, byte_index_nxt;
  logic [7:0]         slot_length_r, slot_length_nxt;
  logic [7:0]         record_length_r, record_length_nxt;
  logic [POS_W-1:0]   position_accum_r, position_accum_nxt;
  logic [POS_W-1:0]   previous_position_r, previous_position_nxt;
  logic               first_record_r, first_record_nxt;
  logic [31:0]        records_count_r, records_count_nxt;
  logic [47:0]        occurrences_count_r, occurrences_count_nxt;
  logic [31:0]        prefix_count_r, prefix_count_nxt;
  logic [15:0]        files_count_r, files_count_nxt;

  logic [7:0]         idx_inc;
  logic [POS_W-1:0]   accum_new;
  logic               pos_done;
  logic               bad_len;
  logic               falls;
  logic               term_end;
  logic               pre;
  logic [POS_W:0]     sum_first;
  logic [CNT_W-1:0]   cnt;
  logic [32:0]        cnt_field;
  logic [OS_W-1:0]    occ_sum;
  logic [47:0]        occ_new;

  assign idx_inc   = byte_index_r + 8'd1;
  assign accum_new = {position_accum_r[POS_W-9:0], data_byte};
  assign pos_done  = (phase_r == irsp_pkg::PH_POS) && (idx_inc == 8'(POSITION_BYTES));
  assign term_end  = idx_inc >= slot_length_r;
  assign bad_len   = record_length_r > slot_length_r;
  assign falls     = !first_record_r && (accum_new < previous_position_r);
  assign pre       = record_length_r == slot_length_r;
  assign sum_first = (POS_W + 1)'(accum_new) + (POS_W + 1)'(1);

  always_comb begin
    if (first_record_r) begin
      if ((CNT_W == POS_W) && (&accum_new)) begin
        cnt = '1;
      end else begin
        cnt = CNT_W'(sum_first);
      end
    end else begin
      cnt = CNT_W'(accum_new - previous_position_r);
    end
  end

  assign cnt_field = (cnt > CNT_W'(irsp_pkg::TERM_COUNT_MAX)) ? irsp_pkg::TERM_COUNT_MAX
                                                              : cnt[32:0];
  assign occ_sum   = OS_W'(occurrences_count_r) + OS_W'(cnt);
  assign occ_new   = (occ_sum > OS_W'(irsp_pkg::OCC_MAX)) ? irsp_pkg::OCC_MAX
                                                          : occ_sum[47:0];

  always_comb begin
    phase_nxt = phase_r;
    if (item_en) begin
      if (end_of_file) begin
        phase_nxt = irsp_pkg::PH_SLOT;
      end else begin
        unique case (phase_r)
          irsp_pkg::PH_SLOT: begin
            phase_nxt = (data_byte == 8'd0) ? irsp_pkg::PH_WAIT : irsp_pkg::PH_CHARSET;
          end
          irsp_pkg::PH_CHARSET: begin
            phase_nxt = irsp_pkg::PH_LEN;
          end
          irsp_pkg::PH_LEN: begin
            phase_nxt = irsp_pkg::PH_TERM;
          end
          irsp_pkg::PH_TERM: begin
            if (term_end) begin
              phase_nxt = irsp_pkg::PH_POS;
            end
          end
          irsp_pkg::PH_POS: begin
            if (pos_done) begin
              phase_nxt = (bad_len || falls) ? irsp_pkg::PH_WAIT : irsp_pkg::PH_LEN;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  always_comb begin
    byte_index_nxt        = byte_index_r;
    slot_length_nxt       = slot_length_r;
    record_length_nxt     = record_length_r;
    position_accum_nxt    = position_accum_r;
    previous_position_nxt = previous_position_r;
    first_record_nxt      = first_record_r;
    records_count_nxt     = records_count_r;
    occurrences_count_nxt = occurrences_count_r;
    prefix_count_nxt      = prefix_count_r;
    files_count_nxt       = files_count_r;
    res_valid             = 1'b0;
    res                   = '0;
    if (item_en) begin
      if (end_of_file) begin
        byte_index_nxt   = 8'd0;
        first_record_nxt = 1'b1;
        unique case (phase_r) inside
          irsp_pkg::PH_SLOT, irsp_pkg::PH_CHARSET: begin
            res_valid      = 1'b1;
            res.kind       = irsp_pkg::KIND_ERROR;
            res.error_code = irsp_pkg::ERR_BAD_HEADER;
          end
          irsp_pkg::PH_TERM, irsp_pkg::PH_POS: begin
            res_valid      = 1'b1;
            res.kind       = irsp_pkg::KIND_ERROR;
            res.error_code = irsp_pkg::ERR_TRUNCATED;
          end
          irsp_pkg::PH_LEN: begin
            files_count_nxt = (&files_count_r) ? files_count_r : files_count_r + 16'd1;
            res_valid       = 1'b1;
            res.kind        = irsp_pkg::KIND_FILE;
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end else begin
        unique case (phase_r)
          irsp_pkg::PH_SLOT: begin
            slot_length_nxt       = data_byte;
            first_record_nxt      = 1'b1;
            previous_position_nxt = '0;
            if (data_byte == 8'd0) begin
              res_valid      = 1'b1;
              res.kind       = irsp_pkg::KIND_ERROR;
              res.error_code = irsp_pkg::ERR_BAD_HEADER;
            end
          end
          irsp_pkg::PH_LEN: begin
            record_length_nxt = data_byte;
            byte_index_nxt    = 8'd0;
          end
          irsp_pkg::PH_TERM: begin
            byte_index_nxt = term_end ? 8'd0 : idx_inc;
            if (byte_index_r < record_length_r) begin
              res_valid     = 1'b1;
              res.kind      = irsp_pkg::KIND_TERM;
              res.term_byte = data_byte;
            end
          end
          irsp_pkg::PH_POS: begin
            position_accum_nxt = accum_new;
            byte_index_nxt     = pos_done ? 8'd0 : idx_inc;
            if (pos_done) begin
              res_valid = 1'b1;
              if (bad_len) begin
                res.kind       = irsp_pkg::KIND_ERROR;
                res.error_code = irsp_pkg::ERR_BAD_LENGTH;
              end else if (falls) begin
                res.kind       = irsp_pkg::KIND_ERROR;
                res.error_code = irsp_pkg::ERR_POS_FALLS;
              end else begin
                records_count_nxt     = (&records_count_r) ? records_count_r
                                                           : records_count_r + 32'd1;
                occurrences_count_nxt = occ_new;
                if (pre && !(&prefix_count_r)) begin
                  prefix_count_nxt = prefix_count_r + 32'd1;
                end
                previous_position_nxt = accum_new;
                first_record_nxt      = 1'b0;
                res.kind              = irsp_pkg::KIND_RECORD;
                res.term_count        = cnt_field;
                res.term_length       = record_length_r;
                res.is_prefix         = pre;
              end
            end
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
    end
    res.records_total        = records_count_nxt;
    res.occurrences_total    = occurrences_count_nxt;
    res.prefix_records_total = prefix_count_nxt;
    res.files_total          = files_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r             <= irsp_pkg::PH_SLOT;
      byte_index_r        <= 8'd0;
      slot_length_r       <= 8'd0;
      record_length_r     <= 8'd0;
      position_accum_r    <= '0;
      previous_position_r <= '0;
      first_record_r      <= 1'b1;
      records_count_r     <= 32'd0;
      occurrences_count_r <= 48'd0;
      prefix_count_r      <= 32'd0;
      files_count_r       <= 16'd0;
    end else begin
      phase_r             <= phase_nxt;
      byte_index_r        <= byte_index_nxt;
      slot_length_r       <= slot_length_nxt;
      record_length_r     <= record_length_nxt;
      position_accum_r    <= position_accum_nxt;
      previous_position_r <= previous_position_nxt;
      first_record_r      <= first_record_nxt;
      records_count_r     <= records_count_nxt;
      occurrences_count_r <= occurrences_count_nxt;
      prefix_count_r      <= prefix_count_nxt;
      files_count_r       <= files_count_nxt;
    end
  end

endmodule

// ----- hw/rtl/irsp_out_reg.sv -----
// ----------------------------------------------------------------------------
// Index record stream parser output register
// Holds one result beat until the receiver takes it and tells the step
// logic when a new result may be loaded.
// ----------------------------------------------------------------------------
module irsp_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  irsp_pkg::res_t res,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_ready,
  output irsp_pkg::res_t out_res
);

  logic           valid_r, valid_nxt;
  irsp_pkg::res_t data_r, data_nxt;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = data_r;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = res;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ----- tb/tb_index_record_stream_parser.sv -----
// ----------------------------------------------------------------------------
// Index record stream parser testbench
// Streams index files into the parser one byte per beat. Most files are
// well formed, with random term bytes and non-falling positions. The rest
// carry a zero slot length, an end of file inside the header, a truncation, a
// bad length, a falling position, or plain noise. A scoreboard tracks the
// parse state and the running totals, and checks each result field by
// field. Both sides of the stream stall at random, except in the last run.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_index_record_stream_parser;

  localparam int POS_BYTES    = irsp_pkg::DEF_POSITION_BYTES;
  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_BEATS = 1450;

  class index_result_checker;
    irsp_pkg::phase_t parse_phase;
    bit [7:0]         byte_index;
    bit [7:0]         slot_len;
    bit [7:0]         rec_len;
    bit [63:0]        pos_acc;
    bit [63:0]        prev_pos;
    bit               first_rec;
    bit [31:0]        records;
    bit [47:0]        occurrences;
    bit [31:0]        prefixes;
    bit [15:0]        files;
    irsp_pkg::res_t   pending_results[$];
    int unsigned      mismatches;

    function new();
      parse_phase = irsp_pkg::PH_SLOT;
      byte_index  = '0;
      slot_len    = '0;
      rec_len     = '0;
      pos_acc     = '0;
      prev_pos    = '0;
      first_rec   = 1'b1;
      records     = '0;
      occurrences = '0;
      prefixes    = '0;
      files       = '0;
      mismatches  = 0;
    endfunction

    function irsp_pkg::res_t with_totals(irsp_pkg::kind_t k);
      irsp_pkg::res_t r;
      r = '0;
      r.kind                 = k;
      r.records_total        = records;
      r.occurrences_total    = occurrences;
      r.prefix_records_total = prefixes;
      r.files_total          = files;
      return r;
    endfunction

    function void raise_error(irsp_pkg::err_t code, irsp_pkg::phase_t next);
      irsp_pkg::res_t r;
      r = with_totals(irsp_pkg::KIND_ERROR);
      r.error_code = code;
      parse_phase = next;
      pending_results.push_back(r);
    endfunction

    function void predict_beat(logic [7:0] b, logic eof);
      irsp_pkg::phase_t was;
      bit               shown;
      bit               pre;
      longint unsigned  cnt;
      irsp_pkg::res_t   r;
      if (eof) begin
        was         = parse_phase;
        parse_phase = irsp_pkg::PH_SLOT;
        first_rec   = 1'b1;
        byte_index  = '0;
        case (was) inside
          irsp_pkg::PH_SLOT, irsp_pkg::PH_CHARSET:
            raise_error(irsp_pkg::ERR_BAD_HEADER, irsp_pkg::PH_SLOT);
          irsp_pkg::PH_TERM, irsp_pkg::PH_POS:
            raise_error(irsp_pkg::ERR_TRUNCATED, irsp_pkg::PH_SLOT);
          irsp_pkg::PH_LEN: begin
            if (files != '1) files++;
            pending_results.push_back(with_totals(irsp_pkg::KIND_FILE));
          end
          default: ;
        endcase
        return;
      end
      case (parse_phase)
        irsp_pkg::PH_SLOT: begin
          slot_len  = b;
          first_rec = 1'b1;
          prev_pos  = '0;
          if (b == 8'd0) raise_error(irsp_pkg::ERR_BAD_HEADER, irsp_pkg::PH_WAIT);
          else parse_phase = irsp_pkg::PH_CHARSET;
        end
        irsp_pkg::PH_CHARSET: parse_phase = irsp_pkg::PH_LEN;
        irsp_pkg::PH_LEN: begin
          rec_len     = b;
          byte_index  = '0;
          parse_phase = irsp_pkg::PH_TERM;
        end
        irsp_pkg::PH_TERM: begin
          shown = byte_index < rec_len;
          byte_index++;
          if (byte_index >= slot_len) begin
            parse_phase = irsp_pkg::PH_POS;
            byte_index  = '0;
            pos_acc     = '0;
          end
          if (shown) begin
            r = with_totals(irsp_pkg::KIND_TERM);
            r.term_byte = b;
            pending_results.push_back(r);
          end
        end
        irsp_pkg::PH_POS: begin
          pos_acc = {pos_acc[55:0], b};
          byte_index++;
          if (byte_index >= POS_BYTES) begin
            byte_index = '0;
            if (rec_len > slot_len) begin
              raise_error(irsp_pkg::ERR_BAD_LENGTH, irsp_pkg::PH_WAIT);
            end else if (!first_rec && pos_acc < prev_pos) begin
              raise_error(irsp_pkg::ERR_POS_FALLS, irsp_pkg::PH_WAIT);
            end else begin
              if (first_rec) cnt = (pos_acc == '1) ? pos_acc : pos_acc + 64'd1;
              else cnt = pos_acc - prev_pos;
              pre = (rec_len == slot_len);
              if (records != '1) records++;
              if (cnt >= irsp_pkg::OCC_MAX - occurrences) occurrences = irsp_pkg::OCC_MAX;
              else occurrences = occurrences + cnt;
              if (pre && prefixes != '1) prefixes++;
              prev_pos    = pos_acc;
              first_rec   = 1'b0;
              parse_phase = irsp_pkg::PH_LEN;
              r = with_totals(irsp_pkg::KIND_RECORD);
              r.term_count  = (cnt > irsp_pkg::TERM_COUNT_MAX) ? irsp_pkg::TERM_COUNT_MAX
                                                               : cnt[32:0];
              r.term_length = rec_len;
              r.is_prefix   = pre;
              pending_results.push_back(r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [183:0] d, logic [1:0] k);
      irsp_pkg::res_t got;
      irsp_pkg::res_t want;
      got.kind                 = irsp_pkg::kind_t'(k);
      got.term_byte            = d[7:0];
      got.term_count           = d[40:8];
      got.term_length          = d[48:41];
      got.is_prefix            = d[49];
      got.error_code           = irsp_pkg::err_t'(d[51:50]);
      got.records_total        = d[83:52];
      got.occurrences_total    = d[131:84];
      got.prefix_records_total = d[163:132];
      got.files_total          = d[179:164];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d tdata=%h", k, d);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("expected kind=%0d byte=%h count=%h len=%h prefix=%b err=%0d",
                   want.kind, want.term_byte, want.term_count, want.term_length,
                   want.is_prefix, want.error_code);
          $display("         totals=%0d/%0d/%0d/%0d",
                   want.records_total, want.occurrences_total,
                   want.prefix_records_total, want.files_total);
          $display("actual   kind=%0d byte=%h count=%h len=%h prefix=%b err=%0d",
                   got.kind, got.term_byte, got.term_count, got.term_length,
                   got.is_prefix, got.error_code);
          $display("         totals=%0d/%0d/%0d/%0d",
                   got.records_total, got.occurrences_total,
                   got.prefix_records_total, got.files_total);
        end
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'd0;
  logic         in_tlast   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [183:0] out_tdata;
  logic [1:0]   out_tuser;

  int unsigned snd_idle     = 12;
  int unsigned rcv_idle     = 61;
  int unsigned beats_sent   = 0;
  int unsigned quiet_cycles = 0;

  index_result_checker checker_sb = new();

  bit [8:0] directed_beats [24] = '{
    9'h100,
    9'h000, 9'h0AB, 9'h100,
    9'h005, 9'h100,
    9'h002, 9'h0C3, 9'h100,
    9'h001, 9'h0FF,
    9'h000, 9'h0FF, 9'h000, 9'h000, 9'h000, 9'h000,
    9'h001, 9'h000, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
    9'h100
  };

  index_record_stream_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) checker_sb.predict_beat(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) checker_sb.check_result(out_tdata, out_tuser);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("index_record_stream_parser regression: fail");
    $finish;
  end

  task automatic send_beat(input bit [7:0] b, input bit eof);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eof;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (checker_sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_file();
    bit [7:0]    file_q[$];
    int unsigned slot;
    int unsigned nrec;
    int unsigned len;
    int unsigned r;
    int unsigned cut;
    bit [31:0]   pos;
    bit [31:0]   prev;
    r = $urandom_range(99);
    if (r < 3) slot = 255;
    else if (r < 30) slot = $urandom_range(5, 32);
    else slot = $urandom_range(1, 4);
    nrec = (slot == 255) ? $urandom_range(1, 2) : $urandom_range(0, 8);
    prev = '0;
    file_q.push_back(slot[7:0]);
    file_q.push_back(8'($urandom_range(255)));
    for (int i = 0; i < nrec; i++) begin
      r = $urandom_range(99);
      if (r < 40) len = slot;
      else if (r < 50) len = 0;
      else if (r < 54 && slot < 255) len = $urandom_range(slot + 1, 255);
      else len = $urandom_range(0, slot);
      file_q.push_back(len[7:0]);
      repeat (slot) file_q.push_back(8'($urandom_range(255)));
      r = $urandom_range(99);
      if (i == 0) begin
        if (r < 10) pos = '1;
        else if (r < 20) pos = '0;
        else if (r < 60) pos = $urandom_range(0, 1000);
        else pos = $urandom;
      end else if (r < 4 && prev != 0) begin
        pos = prev - $urandom_range(1, prev);
      end else if (r < 20) begin
        pos = prev;
      end else if (r < 75) begin
        pos = prev + $urandom_range(1, 500);
      end else begin
        pos = prev + $urandom;
      end
      prev = pos;
      for (int k = POS_BYTES - 1; k >= 0; k--) file_q.push_back(8'(pos >> (8 * k)));
    end
    r = $urandom_range(99);
    if (r < 5) begin
      file_q[0] = 8'd0;
    end else if (r < 10) begin
      cut = $urandom_range(0, 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
    end else if (r < 17 && file_q.size() > 3) begin
      cut = $urandom_range(3, file_q.size() - 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
    end else if (r < 20) begin
      file_q.delete();
      repeat ($urandom_range(0, 20)) file_q.push_back(8'($urandom_range(255)));
    end
    foreach (file_q[i]) send_beat(file_q[i], 1'b0);
    send_beat(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_beats[i]) send_beat(directed_beats[i][7:0], directed_beats[i][8]);
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS / 3) send_random_file();
    wait_for_results();
    snd_idle = 61;
    rcv_idle = 12;
    while (beats_sent < 2 * RANDOM_BEATS / 3) send_random_file();
    wait_for_results();
    snd_idle = 0;
    rcv_idle = 0;
    while (beats_sent < RANDOM_BEATS) send_random_file();
    wait_for_results();
    repeat (20) @(posedge clk);
    if (checker_sb.mismatches == 0 && checker_sb.pending_results.size() == 0) begin
      $display("index_record_stream_parser regression: pass");
    end else begin
      $display("index_record_stream_parser regression: fail");
    end
    $finish;
  end

endmodule
